[rtl/tfun_pkg.sv]
package tfun_pkg;

  localparam int unsigned CoordW = 20;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned MagW = 42;
  localparam int unsigned TW = 24;
  localparam int unsigned NormPos = TW - 1;
  localparam int unsigned SqW = 2 * TW;
  localparam int unsigned SumW = SqW + 2;
  localparam int unsigned RootW = 25;
  localparam int unsigned SqrtRemW = SumW + 1;
  localparam int unsigned QW = 15;
  localparam int unsigned NumW = TW + QW + 2;
  localparam int unsigned DivW = RootW + 1;
  localparam int unsigned IdxW = 16;
  localparam int unsigned NrmW = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] second_index;
    logic [IdxW-1:0] third_index;
  } in_t;

  typedef struct packed {
    logic signed [NrmW-1:0] normal_x;
    logic signed [NrmW-1:0] normal_y;
    logic signed [NrmW-1:0] normal_z;
    logic [IdxW-1:0] out_first_index;
    logic [IdxW-1:0] out_second_index;
    logic [IdxW-1:0] out_third_index;
    logic degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0][IdxW-1:0] idx;
    logic [2:0] neg;
    logic degen;
  } side_t;

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    side_t side;
  } crs_t;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [2:0][TW-1:0] t;
    side_t side;
  } nrm_t;

  typedef struct packed {
    logic [RootW-1:0] root;
    logic [2:0][TW-1:0] t;
    side_t side;
  } rt_t;

endpackage

[rtl/triangle_face_unit_normal_top.sv]
// channel  | valid      | ready      | payload
// request  | in_valid_i | in_ready_o | in_req_i  (tfun_pkg::in_t)
// response | out_valid_o| out_ready_i| out_rsp_o (tfun_pkg::out_t)
// One request per cycle unless a held response stalls the pipe; stages: cross
// product (3), normalize and sum of squares (4), square root one bit per stage
// (25), three dividers one quotient bit per stage (15), output register (1).
// All stages advance together; a held response stalls the whole pipe.
// Reset clears only the valid bits.
module triangle_face_unit_normal_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tfun_pkg::in_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tfun_pkg::out_t  out_rsp_o
);

  logic en;
  logic crs_vld, nrm_vld, rt_vld;
  tfun_pkg::crs_t crs;
  tfun_pkg::nrm_t nrm;
  tfun_pkg::rt_t rt;

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  tfun_cross u_cross (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .req_i(in_req_i),
    .vld_o(crs_vld), .crs_o(crs)
  );

  tfun_norm u_norm (
    .clk_i, .rst_ni, .en_i(en), .vld_i(crs_vld), .crs_i(crs),
    .vld_o(nrm_vld), .nrm_o(nrm)
  );

  tfun_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(nrm_vld), .nrm_i(nrm),
    .vld_o(rt_vld), .rt_o(rt)
  );

  tfun_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(rt_vld), .rt_i(rt),
    .vld_o(out_valid_o), .rsp_o(out_rsp_o)
  );

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.degenerate |->
      out_rsp_o.normal_x == '0 && out_rsp_o.normal_y == '0 && out_rsp_o.normal_z == '0)
    else $error("degenerate normal not zero");

  a_nondegen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.degenerate |->
      out_rsp_o.normal_x != '0 || out_rsp_o.normal_y != '0 || out_rsp_o.normal_z != '0)
    else $error("normal lost its length");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_rsp_o.normal_x >= -16'sd16384 && out_rsp_o.normal_x <= 16'sd16384 &&
      out_rsp_o.normal_y >= -16'sd16384 && out_rsp_o.normal_y <= 16'sd16384 &&
      out_rsp_o.normal_z >= -16'sd16384 && out_rsp_o.normal_z <= 16'sd16384)
    else $error("normal component out of range");

endmodule

[rtl/tfun_cross.sv]
module tfun_cross (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  tfun_pkg::in_t   req_i,
  output logic            vld_o,
  output tfun_pkg::crs_t  crs_o
);

  localparam int unsigned DW = tfun_pkg::DiffW;
  localparam int unsigned PW = tfun_pkg::ProdW;

  logic [2:0] vld_q;
  logic signed [DW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [PW-1:0] p_q [6];
  tfun_pkg::side_t side1_q, side2_q;
  tfun_pkg::crs_t crs_q, crs_d;
  logic signed [PW:0] n [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= {req_i.bx[19], req_i.bx} - {req_i.ax[19], req_i.ax};
      uy_q <= {req_i.by[19], req_i.by} - {req_i.ay[19], req_i.ay};
      uz_q <= {req_i.bz[19], req_i.bz} - {req_i.az[19], req_i.az};
      vx_q <= {req_i.cx[19], req_i.cx} - {req_i.bx[19], req_i.bx};
      vy_q <= {req_i.cy[19], req_i.cy} - {req_i.by[19], req_i.by};
      vz_q <= {req_i.cz[19], req_i.cz} - {req_i.bz[19], req_i.bz};
      side1_q.idx <= {req_i.third_index, req_i.second_index, req_i.first_index};
      side1_q.neg <= '0;
      side1_q.degen <= 1'b0;
      p_q[0] <= uy_q * vz_q;
      p_q[1] <= uz_q * vy_q;
      p_q[2] <= uz_q * vx_q;
      p_q[3] <= ux_q * vz_q;
      p_q[4] <= ux_q * vy_q;
      p_q[5] <= uy_q * vx_q;
      side2_q <= side1_q;
      crs_q <= crs_d;
    end
  end

  always_comb begin
    crs_d.side = side2_q;
    for (int i = 0; i < 3; i++) begin
      n[i] = {p_q[2*i][PW-1], p_q[2*i]} - {p_q[2*i+1][PW-1], p_q[2*i+1]};
      crs_d.side.neg[i] = n[i][PW];
      crs_d.mag[i] = n[i][PW] ? tfun_pkg::MagW'(-n[i]) : tfun_pkg::MagW'(n[i]);
    end
    crs_d.side.degen = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  end

  assign vld_o = vld_q[2];
  assign crs_o = crs_q;

endmodule

[rtl/tfun_norm.sv]
module tfun_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  tfun_pkg::crs_t  crs_i,
  output logic            vld_o,
  output tfun_pkg::nrm_t  nrm_o
);

  localparam int unsigned MW = tfun_pkg::MagW;
  localparam int unsigned TW = tfun_pkg::TW;
  localparam int unsigned PosW = $clog2(MW);

  logic [3:0] vld_q;
  logic [MW-1:0] or_w;
  logic [PosW-1:0] pos_d, pos_q;
  tfun_pkg::crs_t crs_q;
  logic [2:0][TW-1:0] t_d, t_q, t2_q;
  logic [tfun_pkg::SqW-1:0] sq_q [3];
  tfun_pkg::side_t side5_q, side6_q;
  tfun_pkg::nrm_t nrm_q;

  always_comb begin
    or_w = crs_i.mag[0] | crs_i.mag[1] | crs_i.mag[2];
    pos_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (or_w[i]) begin
        pos_d = PosW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_q >= PosW'(tfun_pkg::NormPos)) begin
        t_d[i] = TW'(crs_q.mag[i] >> (pos_q - PosW'(tfun_pkg::NormPos)));
      end else begin
        t_d[i] = TW'(crs_q.mag[i] << (PosW'(tfun_pkg::NormPos) - pos_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crs_q <= crs_i;
      pos_q <= pos_d;
      t_q <= t_d;
      side5_q <= crs_q.side;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= t_q[i] * t_q[i];
      end
      t2_q <= t_q;
      side6_q <= side5_q;
      nrm_q.sum <= tfun_pkg::SumW'(sq_q[0]) + tfun_pkg::SumW'(sq_q[1])
                 + tfun_pkg::SumW'(sq_q[2]);
      nrm_q.t <= t2_q;
      nrm_q.side <= side6_q;
    end
  end

  assign vld_o = vld_q[3];
  assign nrm_o = nrm_q;

endmodule

[rtl/tfun_sqrt.sv]
module tfun_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  tfun_pkg::nrm_t  nrm_i,
  output logic            vld_o,
  output tfun_pkg::rt_t   rt_o
);

  localparam int unsigned NS = tfun_pkg::RootW;
  localparam int unsigned RW = tfun_pkg::SqrtRemW;

  logic [NS-1:0] vld_q;
  logic [RW-1:0] rem_q [NS];
  logic [RW-1:0] res_q [NS];
  logic [2:0][tfun_pkg::TW-1:0] t_q [NS];
  tfun_pkg::side_t side_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (NS - 1 - k));
    logic [RW-1:0] rem_in, res_in, trial;
    logic [2:0][tfun_pkg::TW-1:0] t_in;
    tfun_pkg::side_t side_in;

    if (k == 0) begin : g_first
      assign rem_in = RW'(nrm_i.sum);
      assign res_in = '0;
      assign t_in = nrm_i.t;
      assign side_in = nrm_i.side;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign t_in = t_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + Bit;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
        t_q[k] <= t_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign rt_o.root = res_q[NS-1][NS-1:0];
  assign rt_o.t = t_q[NS-1];
  assign rt_o.side = side_q[NS-1];

endmodule

[rtl/tfun_div.sv]
module tfun_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  tfun_pkg::rt_t   rt_i,
  output logic            vld_o,
  output tfun_pkg::out_t  rsp_o
);

  localparam int unsigned NS = tfun_pkg::QW;
  localparam int unsigned NW = tfun_pkg::NumW;
  localparam int unsigned DW = tfun_pkg::DivW;
  localparam int unsigned OW = tfun_pkg::NrmW;

  logic [NS:0] vld_q;
  logic [2:0][NW-1:0] rem_q [NS];
  logic [2:0][NS-1:0] q_q [NS];
  logic [DW-1:0] d_q [NS];
  tfun_pkg::side_t side_q [NS];
  tfun_pkg::out_t rsp_q, rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], vld_i};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int unsigned Sh = NS - 1 - k;
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][NS-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [NW-1:0] cmp;
    tfun_pkg::side_t side_in;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {NW'(rt_i.t[l]) << NS} + NW'(rt_i.root);
      end
      assign q_in = '0;
      assign d_in = {rt_i.root, 1'b0};
      assign side_in = rt_i.side;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in = q_q[k-1];
      assign d_in = d_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cmp = NW'(d_in) << Sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= cmp) begin
            rem_q[k][l] <= rem_in[l] - cmp;
            q_q[k][l] <= q_in[l] | (NS'(1) << Sh);
          end else begin
            rem_q[k][l] <= rem_in[l];
            q_q[k][l] <= q_in[l];
          end
        end
        d_q[k] <= d_in;
        side_q[k] <= side_in;
      end
    end
  end

  function automatic logic [OW-1:0] apply_sign(input logic neg, input logic [NS-1:0] q,
                                               input logic degen);
    logic [OW-1:0] v;
    v = {1'b0, q};
    if (degen) begin
      return '0;
    end
    return neg ? -v : v;
  endfunction

  always_comb begin
    tfun_pkg::side_t s;
    s = side_q[NS-1];
    rsp_d.normal_x = apply_sign(s.neg[0], q_q[NS-1][0], s.degen);
    rsp_d.normal_y = apply_sign(s.neg[1], q_q[NS-1][1], s.degen);
    rsp_d.normal_z = apply_sign(s.neg[2], q_q[NS-1][2], s.degen);
    rsp_d.out_first_index = s.idx[0];
    rsp_d.out_second_index = s.idx[1];
    rsp_d.out_third_index = s.idx[2];
    rsp_d.degenerate = s.degen;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign vld_o = vld_q[NS];
  assign rsp_o = rsp_q;

endmodule
